### rtl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg: shared definitions of the positional list engine
// Sizes, operation and status codes, the cell command and a last-match encoder.
// ----------------------------------------------------------------------------
package plc_pkg;

   localparam int CAPACITY = 64;
   localparam int VALUE_W  = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int POS_W    = IDX_W + 1;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic [POS_W-1:0] NO_MATCH = '1;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      logic                en;
      cell_op_type         op;
      logic [POS_W-1:0]    pos;
      logic [VALUE_W-1:0]  val;
      logic [POS_W-1:0]    count;
   } cell_cmd_type;

   // Highest set bit of the match vector, or all ones when none is set.
   function automatic logic [POS_W-1:0] last_match(input logic [CAPACITY-1:0] match);
      logic [POS_W-1:0] idx;
      idx = NO_MATCH;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match[i]) begin
            idx = POS_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

### rtl/plc_cell.sv
// ----------------------------------------------------------------------------
// plc_cell: one place of the list
// Holds one value, takes its neighbor's value on a shift and flags a match.
// ----------------------------------------------------------------------------
module plc_cell (
   input  logic                         clock,
   input  logic [plc_pkg::IDX_W-1:0]    cell_index,
   input  plc_pkg::cell_cmd_type        cmd,
   input  logic [plc_pkg::VALUE_W-1:0]  left_value,
   input  logic [plc_pkg::VALUE_W-1:0]  right_value,
   output logic [plc_pkg::VALUE_W-1:0]  value,
   output logic                         match
);

   logic [plc_pkg::VALUE_W-1:0] value_ff;
   logic [plc_pkg::VALUE_W-1:0] value_in;
   logic                        match_ff;
   logic                        match_in;
   logic [plc_pkg::POS_W-1:0]   my_pos;

   assign my_pos = {1'b0, cell_index};

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         plc_pkg::CELL_WRITE: begin
            if (my_pos == cmd.pos) begin
               value_in = cmd.val;
            end
         end
         plc_pkg::CELL_INSERT: begin
            // Places above the insert point take the value from below.
            if (my_pos == cmd.pos) begin
               value_in = cmd.val;
            end else if (my_pos > cmd.pos) begin
               value_in = left_value;
            end
         end
         plc_pkg::CELL_REMOVE: begin
            if (my_pos >= cmd.pos) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
      match_in = (my_pos < cmd.count) && (value_ff == cmd.val);
   end

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         value_ff <= value_in;
         match_ff <= match_in;
      end
   end

   assign value = value_ff;
   assign match = match_ff;

endmodule

### rtl/plc_chain.sv
// ----------------------------------------------------------------------------
// plc_chain: the row of list cells
// Links each cell to its neighbors and selects the value at a read position.
// ----------------------------------------------------------------------------
module plc_chain (
   input  logic                          clock,
   input  plc_pkg::cell_cmd_type         cmd,
   input  logic [plc_pkg::IDX_W-1:0]     rd_index,
   output logic [plc_pkg::VALUE_W-1:0]   rd_value,
   output logic [plc_pkg::CAPACITY-1:0]  match_vec
);

   logic [plc_pkg::VALUE_W-1:0] cell_value [plc_pkg::CAPACITY];

   for (genvar g = 0; g < plc_pkg::CAPACITY; g++) begin : g_cell
      logic [plc_pkg::VALUE_W-1:0] left_value;
      logic [plc_pkg::VALUE_W-1:0] right_value;

      // The end cells never shift in from outside the row.
      if (g == 0) begin : g_first
         assign left_value = cell_value[g];
      end else begin : g_inner_left
         assign left_value = cell_value[g-1];
      end
      if (g == plc_pkg::CAPACITY - 1) begin : g_last
         assign right_value = cell_value[g];
      end else begin : g_inner_right
         assign right_value = cell_value[g+1];
      end

      plc_cell u_cell (
         .clock       (clock),
         .cell_index  (plc_pkg::IDX_W'(g)),
         .cmd         (cmd),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[g]),
         .match       (match_vec[g])
      );
   end

   assign rd_value = cell_value[rd_index];

endmodule

### rtl/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit: ordered list with positional access and search
// ----------------------------------------------------------------------------
// Each item is one request on a list of up to 64 values held in a row of
// cells. An accepted item is registered, then checked and carried out on the
// cells, where shifts and all compares of a search happen at once; the next
// stage encodes the last match, and the result then sits in the output
// register. A new item can be accepted every cycle while results are taken.
// A result that waits to be taken lets two more items in before the input
// stalls. The cell row, updated once per item, sets that rate.
// ----------------------------------------------------------------------------
module positional_list_engine_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [plc_pkg::KIND_W-1:0]           req_kind,
   input  logic [plc_pkg::POS_W-1:0]            req_position,
   input  logic signed [plc_pkg::VALUE_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [plc_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [plc_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic signed [plc_pkg::POS_W-1:0]     rsp_found_index,
   output logic [plc_pkg::POS_W-1:0]            rsp_count
);

   // Control
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [plc_pkg::POS_W-1:0] count_ff, count_in;
   logic accept, s1_adv, s2_adv, rsp_free, s1_free;

   // Payload
   logic [plc_pkg::KIND_W-1:0]   s1_kind_ff;
   logic [plc_pkg::POS_W-1:0]    s1_pos_ff;
   logic [plc_pkg::VALUE_W-1:0]  s1_val_ff;
   logic [plc_pkg::STATUS_W-1:0] s2_status_ff, status_in;
   logic [plc_pkg::VALUE_W-1:0]  s2_rd_ff, rd_in;
   logic                         s2_search_ff;
   logic [plc_pkg::POS_W-1:0]    s2_count_ff;
   logic [plc_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [plc_pkg::VALUE_W-1:0]  rsp_rd_ff;
   logic [plc_pkg::POS_W-1:0]    rsp_found_ff, found_in;
   logic [plc_pkg::POS_W-1:0]    rsp_count_ff;

   plc_pkg::cell_cmd_type        cmd;
   logic [plc_pkg::VALUE_W-1:0]  chain_rd;
   logic [plc_pkg::CAPACITY-1:0] match_vec;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_adv    = s2_valid_ff && rsp_free;
   assign s1_free   = !s2_valid_ff || rsp_free;
   assign s1_adv    = s1_valid_ff && s1_free;
   assign req_stall = s1_valid_ff && !s1_free;
   assign accept    = req_valid && !req_stall;

   // Range and capacity checks against the count before this item, the cell command and the results.
   always_comb begin
      status_in = plc_pkg::STATUS_OK;
      count_in  = count_ff;
      cmd.op    = plc_pkg::CELL_HOLD;
      unique case (s1_kind_ff) inside
         plc_pkg::KIND_READ, plc_pkg::KIND_WRITE, plc_pkg::KIND_REMOVE: begin
            if (s1_pos_ff >= count_ff) begin
               status_in = plc_pkg::STATUS_RANGE;
            end else if (s1_kind_ff == plc_pkg::KIND_WRITE) begin
               cmd.op = plc_pkg::CELL_WRITE;
            end else if (s1_kind_ff == plc_pkg::KIND_REMOVE) begin
               cmd.op   = plc_pkg::CELL_REMOVE;
               count_in = count_ff - 1'b1;
            end
         end
         plc_pkg::KIND_INSERT: begin
            if (s1_pos_ff > count_ff) begin
               status_in = plc_pkg::STATUS_RANGE;
            end else if (count_ff == plc_pkg::POS_W'(plc_pkg::CAPACITY)) begin
               status_in = plc_pkg::STATUS_FULL;
            end else begin
               cmd.op   = plc_pkg::CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            status_in = plc_pkg::STATUS_OK;
         end
      endcase
      cmd.en    = s1_adv;
      cmd.pos   = s1_pos_ff;
      cmd.val   = s1_val_ff;
      cmd.count = count_ff;
      rd_in     = (s1_kind_ff == plc_pkg::KIND_READ && status_in == plc_pkg::STATUS_OK)
                  ? chain_rd : '0;
      found_in  = s2_search_ff ? plc_pkg::last_match(match_vec) : plc_pkg::NO_MATCH;
   end

   plc_chain u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .rd_index  (s1_pos_ff[plc_pkg::IDX_W-1:0]),
      .rd_value  (chain_rd),
      .match_vec (match_vec)
   );

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_adv ? 1'b1 : (rsp_free ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= req_kind;
         s1_pos_ff  <= req_position;
         s1_val_ff  <= req_value;
      end
      if (s1_adv) begin
         s2_status_ff <= status_in;
         s2_rd_ff     <= rd_in;
         s2_search_ff <= (s1_kind_ff == plc_pkg::KIND_SEARCH);
         s2_count_ff  <= count_in;
      end
      if (s2_adv) begin
         rsp_status_ff <= s2_status_ff;
         rsp_rd_ff     <= s2_rd_ff;
         rsp_found_ff  <= found_in;
         rsp_count_ff  <= s2_count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_rd_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_count       = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= plc_pkg::POS_W'(plc_pkg::CAPACITY))
      else $error("list count above capacity");

   a_error_keeps_count: assert property (@(posedge clock) disable iff (reset)
      s1_adv && status_in != plc_pkg::STATUS_OK |=> $stable(count_ff))
      else $error("rejected item changed the count");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      s1_adv && status_in == plc_pkg::STATUS_OK && s1_kind_ff == plc_pkg::KIND_INSERT
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the list");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != plc_pkg::STATUS_OK
      |-> rsp_rd_ff == '0 && rsp_found_ff == plc_pkg::NO_MATCH)
      else $error("failed item carries data");

endmodule

### tb/sv/list_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_check_pkg: result checking for the positional list engine
// Keeps a copy of the list and its count, works out the result of each
// accepted item and compares every returned result with the oldest one due.
// ----------------------------------------------------------------------------
package list_check_pkg;
   import plc_pkg::*;

   // Kind codes above search carry no operation; the block only answers them.
   localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] read_value;
      logic signed [POS_W-1:0]   found_index;
      logic [POS_W-1:0]          count;
   } list_result_type;

   class list_scoreboard;
      logic signed [VALUE_W-1:0] cells[CAPACITY];
      int unsigned               fill;
      list_result_type           awaited_results[$];
      int unsigned               failures;

      function new();
         fill     = 0;
         failures = 0;
         foreach (cells[i]) cells[i] = '0;
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction

      // Applies one accepted item to the copy of the list and queues its result.
      function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                 logic signed [VALUE_W-1:0] value);
         list_result_type res;
         int unsigned     p;
         p               = pos;
         res.status      = STATUS_OK;
         res.read_value  = '0;
         res.found_index = NO_MATCH;
         case (kind)
            KIND_READ: begin
               if (p >= fill) res.status = STATUS_RANGE;
               else res.read_value = cells[p];
            end
            KIND_WRITE: begin
               if (p >= fill) res.status = STATUS_RANGE;
               else cells[p] = value;
            end
            KIND_INSERT: begin
               // The position check wins over the full check.
               if (p > fill) begin
                  res.status = STATUS_RANGE;
               end else if (fill >= CAPACITY) begin
                  res.status = STATUS_FULL;
               end else begin
                  for (int i = fill; i > p; i--) cells[i] = cells[i-1];
                  cells[p] = value;
                  fill++;
               end
            end
            KIND_REMOVE: begin
               if (p >= fill) begin
                  res.status = STATUS_RANGE;
               end else begin
                  for (int i = p; i + 1 < fill; i++) cells[i] = cells[i+1];
                  fill--;
               end
            end
            KIND_SEARCH: begin
               for (int i = 0; i < fill; i++) begin
                  if (cells[i] == value) res.found_index = POS_W'(i);
               end
            end
            default: begin
            end
         endcase
         res.count = POS_W'(fill);
         awaited_results.push_back(res);
      endfunction

      function void check_field(string name, logic [63:0] expected, logic [63:0] actual);
         if (actual !== expected) begin
            $error("%s: expected %0h, actual %0h", name, expected, actual);
            failures++;
         end
      endfunction

      function void check_result(logic [STATUS_W-1:0] status,
                                 logic signed [VALUE_W-1:0] read_value,
                                 logic signed [POS_W-1:0] found_index,
                                 logic [POS_W-1:0] count);
         list_result_type due;
         if (awaited_results.size() == 0) begin
            $error("result with no item outstanding: status %0h, count %0h", status, count);
            failures++;
            return;
         end
         due = awaited_results.pop_front();
         check_field("status", 64'(due.status), 64'(status));
         check_field("read_value", 64'(due.read_value), 64'(read_value));
         check_field("found_index", 64'(due.found_index), 64'(found_index));
         check_field("count", 64'(due.count), 64'(count));
      endfunction
   endclass

endpackage

### tb/sv/positional_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit_tb: self-checking bench of the list engine
// A directed run covers empty and out-of-range positions, edge values, last
// match search and the unused kinds; a long random run then fills the list to
// capacity and drains it again under four pacing modes of both channels.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;
   import plc_pkg::*;
   import list_check_pkg::*;

   typedef enum int {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_type;
   typedef enum int {TREND_FILL, TREND_DRAIN, TREND_MIXED} trend_type;

   localparam int               ITEM_TARGET  = 850;
   localparam int               TREND_SPAN   = 120;
   localparam int               SETTLE_CYCLES = 8;
   localparam logic [POS_W-1:0] POS_MAX      = '1;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic                      req_stall;
   logic [KIND_W-1:0]         req_kind        = '0;
   logic [POS_W-1:0]          req_position    = '0;
   logic signed [VALUE_W-1:0] req_value       = '0;
   logic                      rsp_valid;
   logic                      rsp_stall       = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic signed [POS_W-1:0]   rsp_found_index;
   logic [POS_W-1:0]          rsp_count;

   list_scoreboard list_board = new();
   pace_type       pace       = PACE_FULL;

   logic signed [VALUE_W-1:0] value_pool[8] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0,
      32'shffff_ffff, 32'sh1, 32'sh5a5a_5a5a, 32'sha5a5_a5a5, 32'sh2a};

   positional_list_engine_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) <
                    ((pace == PACE_RECEIVER_STALL) ? 61 : (pace == PACE_BOTH) ? 37 : 0));
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         list_board.check_result(rsp_status, rsp_read_value, rsp_found_index, rsp_count);
      end
   end

   // Entered and left at a falling edge; the item is noted when it is taken.
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                               input logic signed [VALUE_W-1:0] value);
      int unsigned idle_pct;
      idle_pct = (pace == PACE_SENDER_IDLE) ? 61 : (pace == PACE_BOTH) ? 37 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_position <= pos;
      req_value    <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      list_board.note_request(kind, pos, value);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (list_board.pending() != 0) @(negedge clock);
   endtask

   initial begin
      logic [KIND_W-1:0]         kind;
      logic [POS_W-1:0]          pos;
      logic signed [VALUE_W-1:0] value;
      trend_type                 trend;
      int unsigned               roll;
      int unsigned               limit;
      int unsigned               fill;
      int unsigned               done;
      int unsigned               total;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty list: every positional kind is out of range, search finds nothing.
      send_request(KIND_READ, 7'd0, 32'sd0);
      send_request(KIND_REMOVE, 7'd0, 32'sd0);
      send_request(KIND_WRITE, 7'd0, 32'sd9);
      send_request(KIND_INSERT, 7'd1, 32'sd9);
      send_request(KIND_SEARCH, 7'd0, 32'sd0);
      send_request(KIND_INSERT, 7'd0, 32'sh8000_0000);
      send_request(KIND_INSERT, 7'd1, 32'sh7fff_ffff);
      send_request(KIND_INSERT, 7'd0, 32'sd5);
      send_request(KIND_INSERT, 7'd1, 32'sd5);
      // Two equal entries: the later position must be reported.
      send_request(KIND_SEARCH, 7'd0, 32'sd5);
      send_request(KIND_SEARCH, 7'd0, 32'sd12345);
      send_request(KIND_READ, 7'd0, 32'sd0);
      send_request(KIND_READ, 7'd3, 32'sd0);
      send_request(KIND_WRITE, 7'd2, 32'shffff_ffff);
      send_request(KIND_READ, 7'd2, 32'sd0);
      send_request(KIND_READ, 7'd4, 32'sd0);
      send_request(KIND_INSERT, POS_MAX, 32'sd1);
      for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
         send_request(KIND_W'(k), POS_MAX, 32'shffff_ffff);
      end
      send_request(KIND_REMOVE, 7'd0, 32'sd0);
      send_request(KIND_READ, 7'd0, 32'sd0);
      send_request(KIND_REMOVE, 7'd2, 32'sd0);
      send_request(KIND_INSERT, 7'd2, 32'sd0);
      send_request(KIND_SEARCH, 7'd0, 32'shffff_ffff);
      wait_drained();

      total = 0;
      for (int phase = PACE_FULL; phase <= PACE_BOTH; phase++) begin
         pace = pace_type'(phase);
         done = 0;
         while (done < ITEM_TARGET / 4) begin
            // Windows that mostly insert push the list up to capacity and keep it
            // there for a while; windows that mostly remove bring it back down.
            trend = trend_type'((total / TREND_SPAN) % 3);
            fill  = list_board.fill;
            roll  = $urandom_range(99);
            case (trend)
               TREND_FILL: begin
                  kind = (roll < 75) ? KIND_INSERT : (roll < 80) ? KIND_REMOVE :
                         (roll < 88) ? KIND_READ : (roll < 94) ? KIND_WRITE : KIND_SEARCH;
               end
               TREND_DRAIN: begin
                  kind = (roll < 75) ? KIND_REMOVE : (roll < 80) ? KIND_INSERT :
                         (roll < 88) ? KIND_READ : (roll < 94) ? KIND_WRITE : KIND_SEARCH;
               end
               default: begin
                  kind = (roll < 25) ? KIND_INSERT : (roll < 45) ? KIND_REMOVE :
                         (roll < 65) ? KIND_READ : (roll < 80) ? KIND_WRITE : KIND_SEARCH;
               end
            endcase
            if ($urandom_range(99) < 3) begin
               kind = KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
            end

            limit = (kind == KIND_INSERT) ? fill + 1 : fill;
            roll  = $urandom_range(99);
            if (limit == 0 || roll < 10) pos = POS_W'($urandom_range(POS_MAX, limit));
            else if (roll < 25) pos = '0;
            else if (roll < 40) pos = POS_W'(limit - 1);
            else pos = POS_W'($urandom_range(limit - 1, 0));

            roll = $urandom_range(99);
            if (fill != 0 && roll < 30) value = list_board.cells[$urandom_range(fill - 1, 0)];
            else if (roll < 60) value = value_pool[$urandom_range(7, 0)];
            else value = $urandom;

            send_request(kind, pos, value);
            if (kind <= KIND_SEARCH) begin
               done++;
               total++;
            end
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (list_board.failures == 0 && list_board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

### positional_list_engine_unit.f
rtl/plc_pkg.sv
rtl/plc_cell.sv
rtl/plc_chain.sv
rtl/positional_list_engine_unit.sv
tb/sv/list_check_pkg.sv
tb/sv/positional_list_engine_unit_tb.sv
